>>> design/thrce_pkg.sv
`timescale 1ns / 1ps

package thrce_pkg;

  // fixed field widths of the sample and event streams
  localparam int COORD_W   = 12;
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int RANGE_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int KIND_W    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RC_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DUR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_RANGE = 2'd2;

  // event kinds on the output stream
  typedef enum logic [KIND_W-1:0] {
    KIND_X     = 3'd0,
    KIND_Y     = 3'd1,
    KIND_LEFT  = 3'd2,
    KIND_RIGHT = 3'd3,
    KIND_SYNC  = 3'd4
  } kind_t;

  // classified sample handed from the front part to the event sequencer
  typedef struct packed {
    logic               report_xy;   // position events are sent
    logic               fire_right;  // forced right-button transition
    logic               rc_enable;   // right-button event is sent
    logic               right_down;  // button states after the sample
    logic               left_down;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } sample_desc_t;

endpackage

>>> design/thrce_front.sv
`timescale 1ns / 1ps

module thrce_front import thrce_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int NODRAG_MS  = 200
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // sample request
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_pressed,
  input  logic [COORD_W-1:0]   in_x,
  input  logic [COORD_W-1:0]   in_y,
  input  logic [TIME_W-1:0]    in_time,
  // classified sample to the queue
  input  logic                 q_ready,
  output logic                 q_push,
  output sample_desc_t         q_desc
);

  localparam int CB = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int HALF_W = RANGE_W - 1;
  localparam int SW = ((CB > HALF_W) ? CB : HALF_W) + 1;

  logic                rc_enable_r;
  logic [DUR_W-1:0]    hold_dur_r;
  logic [RANGE_W-1:0]  hold_range_r;

  logic                left_down_r, left_down_nxt;
  logic                right_down_r, right_down_nxt;
  logic [TIME_W-1:0]   touch_start_r, touch_start_nxt;
  logic [TIME_W-1:0]   hold_start_r, hold_start_nxt;
  logic [CB-1:0]       held_x_r, held_x_nxt;
  logic [CB-1:0]       held_y_r, held_y_nxt;

  logic [CB-1:0]       x_m, y_m;
  logic                left_a, right_a, first;
  logic [TIME_W-1:0]   diff_t, diff_h;
  logic                report;
  logic [CB-1:0]       hx_eff, hy_eff;
  logic [SW-1:0]       sx_w, sy_w, hx_w, hy_w, half_w;
  logic                in_square, hold_done, hold_twice, fire_cond, restart;

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  // coordinates keep only the low bits in use
  assign x_m = in_x[CB-1:0];
  assign y_m = in_y[CB-1:0];

  // button update from the pressed flag
  always_comb begin
    if (in_pressed) begin
      left_a  = left_down_r | right_down_r ? left_down_r  : 1'b1;
      right_a = left_down_r | right_down_r ? right_down_r : 1'b0;
    end else begin
      left_a  = 1'b0;
      right_a = 1'b0;
    end
    first = ~left_down_r & left_a;
  end

  // elapsed times, a new touch restarts both timers at zero
  assign diff_t = first ? '0 : in_time - touch_start_r;
  assign diff_h = first ? '0 : in_time - hold_start_r;
  assign report = first | (diff_t >= TIME_W'(NODRAG_MS));

  // inside the no-drag window the sample becomes the held position
  assign hx_eff = report ? held_x_r : x_m;
  assign hy_eff = report ? held_y_r : y_m;

  // square test around the sample, strict on all four sides
  assign sx_w   = SW'(x_m);
  assign sy_w   = SW'(y_m);
  assign hx_w   = SW'(hx_eff);
  assign hy_w   = SW'(hy_eff);
  assign half_w = SW'(hold_range_r[RANGE_W-1:1]);
  assign in_square = (hx_w + half_w > sx_w) && (hx_w < sx_w + half_w) &&
                     (hy_w + half_w > sy_w) && (hy_w < sy_w + half_w);

  assign hold_done  = diff_h >= TIME_W'(hold_dur_r);
  assign hold_twice = diff_h >= TIME_W'({hold_dur_r, 1'b0});
  assign fire_cond  = rc_enable_r & hold_done & in_square;

  // right click and hold restart
  always_comb begin
    left_down_nxt  = fire_cond ? 1'b0 : left_a;
    right_down_nxt = fire_cond ? 1'b1 : right_a;
    restart        = rc_enable_r & hold_twice & ~right_down_nxt;
    touch_start_nxt = first ? in_time : touch_start_r;
    hold_start_nxt  = (first | restart) ? in_time : hold_start_r;
    held_x_nxt      = restart ? x_m : hx_eff;
    held_y_nxt      = restart ? y_m : hy_eff;
  end

  // descriptor for the sequencer
  always_comb begin
    q_desc.report_xy  = report;
    q_desc.fire_right = rc_enable_r & ~right_down_r & right_down_nxt;
    q_desc.rc_enable  = rc_enable_r;
    q_desc.right_down = right_down_nxt;
    q_desc.left_down  = left_down_nxt;
    q_desc.x          = COORD_W'(x_m);
    q_desc.y          = COORD_W'(y_m);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_enable_r  <= 1'b1;
      hold_dur_r   <= DUR_W'(1000);
      hold_range_r <= RANGE_W'(10);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RC_ENABLE:  rc_enable_r  <= cfg_data[0];
        CFG_HOLD_DUR:   hold_dur_r   <= cfg_data[DUR_W-1:0];
        CFG_HOLD_RANGE: hold_range_r <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // touch state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_down_r   <= 1'b0;
      right_down_r  <= 1'b0;
      touch_start_r <= '0;
      hold_start_r  <= '0;
      held_x_r      <= '0;
      held_y_r      <= '0;
    end else if (q_push) begin
      left_down_r   <= left_down_nxt;
      right_down_r  <= right_down_nxt;
      touch_start_r <= touch_start_nxt;
      hold_start_r  <= hold_start_nxt;
      held_x_r      <= held_x_nxt;
      held_y_r      <= held_y_nxt;
    end
  end

  // both buttons are never down together
  a_buttons_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(left_down_r && right_down_r))
    else $error("left and right both down");

  // a forced transition always leaves right down and left up
  a_fire_state: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_desc.fire_right) |=> (right_down_r && !left_down_r))
    else $error("right click left wrong button state");

  // right never goes down while the feature is off
  a_fire_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !rc_enable_r && !right_down_r) |=> !right_down_r)
    else $error("right pressed with right click disabled");

endmodule

>>> design/thrce_queue.sv
`timescale 1ns / 1ps

module thrce_queue import thrce_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  sample_desc_t push_desc,
  output logic         not_full,
  input  logic         pop,
  output logic         not_empty,
  output sample_desc_t head_desc
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  sample_desc_t    entry_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign not_full  = count_r != CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign head_desc = entry_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

>>> design/thrce_back.sv
`timescale 1ns / 1ps

module thrce_back import thrce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // head of the queue
  input  logic                q_valid,
  input  sample_desc_t        q_desc,
  output logic                q_pop,
  // event stream
  output logic                out_valid,
  input  logic                out_ready,
  output kind_t               out_kind,
  output logic [COORD_W-1:0]  out_value,
  output logic                out_last
);

  typedef enum logic [3:0] {
    ST_X, ST_Y, ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_R, ST_L, ST_S
  } step_t;

  step_t               step_r, cur_step, next_step;
  logic                active_r;
  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [COORD_W-1:0]  out_value_r;
  logic                out_last_r;
  logic                slot_free, emit;
  kind_t               ev_kind;
  logic [COORD_W-1:0]  ev_value;

  assign slot_free = ~out_valid_r | out_ready;
  assign emit      = q_valid & slot_free;
  assign q_pop     = emit & (cur_step == ST_S);

  // step to emit now: the first one of a fresh sample, or the one in flight
  always_comb begin
    if (active_r) begin
      cur_step = step_r;
    end else if (q_desc.report_xy) begin
      cur_step = ST_X;
    end else if (q_desc.fire_right) begin
      cur_step = ST_F0;
    end else if (q_desc.rc_enable) begin
      cur_step = ST_R;
    end else begin
      cur_step = ST_L;
    end
  end

  // event of the current step and the step after it
  always_comb begin
    ev_value  = '0;
    next_step = ST_S;
    unique case (cur_step)
      ST_X: begin
        ev_kind   = KIND_X;
        ev_value  = q_desc.x;
        next_step = ST_Y;
      end
      ST_Y: begin
        ev_kind   = KIND_Y;
        ev_value  = q_desc.y;
        next_step = q_desc.fire_right ? ST_F0 : (q_desc.rc_enable ? ST_R : ST_L);
      end
      ST_F0: begin
        ev_kind   = KIND_LEFT;
        next_step = ST_F1;
      end
      ST_F1: begin
        ev_kind   = KIND_RIGHT;
        next_step = ST_F2;
      end
      ST_F2: begin
        ev_kind   = KIND_SYNC;
        next_step = ST_F3;
      end
      ST_F3: begin
        ev_kind   = KIND_LEFT;
        next_step = ST_F4;
      end
      ST_F4: begin
        ev_kind   = KIND_RIGHT;
        ev_value  = COORD_W'(1);
        next_step = ST_F5;
      end
      ST_F5: begin
        ev_kind   = KIND_SYNC;
        next_step = ST_R;
      end
      ST_R: begin
        ev_kind   = KIND_RIGHT;
        ev_value  = COORD_W'(q_desc.right_down);
        next_step = ST_L;
      end
      ST_L: begin
        ev_kind   = KIND_LEFT;
        ev_value  = COORD_W'(q_desc.left_down);
        next_step = ST_S;
      end
      ST_S: begin
        ev_kind   = KIND_SYNC;
        next_step = ST_S;
      end
      default: begin
        ev_kind   = KIND_SYNC;
        next_step = ST_S;
      end
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_S;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_kind_r  <= KIND_SYNC;
      out_value_r <= '0;
      out_last_r  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= ev_kind;
        out_value_r <= ev_value;
        out_last_r  <= cur_step == ST_S;
        step_r      <= next_step;
        active_r    <= cur_step != ST_S;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  // a sample in flight always has its descriptor at the queue head
  a_active_head: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> q_valid)
    else $error("sequencer active with empty queue");

  // the closing event of a sample is a sync
  a_last_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == KIND_SYNC))
    else $error("last event is not a sync");

  // a forced transition only comes with right click enabled
  a_fire_en: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_desc.fire_right) |-> (q_desc.rc_enable && q_desc.right_down))
    else $error("forced transition without right click");

endmodule

>>> design/touch_hold_right_click_emulator.sv
`timescale 1ns / 1ps

// Touch press-and-hold right click: each touch sample (pressed flag in
// in_tuser, x, y and a millisecond timestamp in in_tdata) is classified
// combinationally by the front part, which keeps the button states and
// timers, and goes into a two-entry queue. The event sequencer behind it
// sends the resulting events (position, forced right-button transition,
// buttons, sync) one per cycle while out_tready allows, 2 to 11 events per
// sample, so the sustained sample rate is set by the single event port. A
// sample is taken whenever the queue has room, also while earlier events
// still wait on out_tready; the first event of a sample passes through the
// queue entry and then the output register when the output is free.
module touch_hold_right_click_emulator import thrce_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int NODRAG_MS  = 200
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // touch samples
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [55:0]          in_tdata,   // pos_x[11:0], pos_y[23:12], time_ms[55:24]
  input  logic                 in_tuser,   // pressed
  // events
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // event_value[11:0], zero[15:12]
  output logic [KIND_W-1:0]    out_tuser,  // event_kind[2:0]
  output logic                 out_tlast   // last_event
);

  logic         q_push, q_pop, q_not_full, q_not_empty;
  sample_desc_t push_desc, head_desc;
  kind_t        ev_kind;
  logic [COORD_W-1:0] ev_value;

  assign cfg_ready = 1'b1;

  thrce_front #(
    .COORD_BITS (COORD_BITS),
    .NODRAG_MS  (NODRAG_MS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_pressed (in_tuser),
    .in_x       (in_tdata[11:0]),
    .in_y       (in_tdata[23:12]),
    .in_time    (in_tdata[55:24]),
    .q_ready    (q_not_full),
    .q_push     (q_push),
    .q_desc     (push_desc)
  );

  thrce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_desc (head_desc)
  );

  thrce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_desc    (head_desc),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (ev_kind),
    .out_value (ev_value),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'b0, ev_value};
  assign out_tuser = ev_kind;

endmodule

>>> sim/thrce_event_checker.sv
`timescale 1ns / 1ps

module thrce_event_checker import thrce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [55:0]          in_tdata,   // pos_x[11:0], pos_y[23:12], time_ms[55:24]
  input  logic                 in_tuser,   // pressed
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [15:0]          out_tdata,  // event_value[11:0], zero[15:12]
  input  logic [KIND_W-1:0]    out_tuser,  // event_kind[2:0]
  input  logic                 out_tlast,
  output int                   fail_count,
  output int                   pending_events,
  output int                   checked_events,
  output int                   right_clicks
);

  localparam logic [TIME_W:0] NODRAG_LIMIT = 200;

  typedef struct {
    kind_t              kind;
    logic [COORD_W-1:0] value;
    logic               last;
  } touch_event_t;

  // events predicted for accepted samples, oldest first
  touch_event_t queued_events[$];

  // mirrored registers
  logic               rc_enable;
  logic [DUR_W-1:0]   hold_dur;
  logic [RANGE_W-1:0] hold_range;

  // mirrored tracker state
  logic               left_down;
  logic               right_down;
  logic [TIME_W-1:0]  touch_start;
  logic [TIME_W-1:0]  hold_start;
  logic [COORD_W-1:0] held_x;
  logic [COORD_W-1:0] held_y;

  int fails   = 0;
  int checked = 0;
  int clicks  = 0;

  // wrapping difference reaches the limit
  function automatic bit ms_elapsed(input logic [TIME_W-1:0] start,
                                    input logic [TIME_W-1:0] now,
                                    input logic [TIME_W:0] limit);
    logic [TIME_W-1:0] diff;
    diff = now - start;
    return {1'b0, diff} >= limit;
  endfunction

  function automatic void push_event(input kind_t kind, input logic [COORD_W-1:0] value,
                                     input logic last);
    touch_event_t ev;
    ev.kind  = kind;
    ev.value = value;
    ev.last  = last;
    queued_events.push_back(ev);
  endfunction

  // one touch sample: update tracker state and queue its events
  function automatic void predict_touch_events(input logic press,
                                               input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y,
                                               input logic [TIME_W-1:0] now);
    logic was_left;
    logic was_right;
    logic first;
    int   half;
    int   sx;
    int   sy;
    int   hx;
    int   hy;
    was_left  = left_down;
    was_right = right_down;

    // button tracking: touch presses left unless a button is already down
    if (press) begin
      if (!was_left && !was_right) begin
        left_down  = 1'b1;
        right_down = 1'b0;
      end
    end else begin
      left_down  = 1'b0;
      right_down = 1'b0;
    end

    first = !was_left && left_down;
    if (first) begin
      touch_start = now;
      hold_start  = now;
    end

    // position on the first touch and after the no-drag window, else remember it
    if (first || ms_elapsed(touch_start, now, NODRAG_LIMIT)) begin
      push_event(KIND_X, x, 1'b0);
      push_event(KIND_Y, y, 1'b0);
    end else begin
      held_x = x;
      held_y = y;
    end

    if (rc_enable) begin
      half = int'(hold_range >> 1);
      sx   = int'(x);
      sy   = int'(y);
      hx   = int'(held_x);
      hy   = int'(held_y);

      // hold long enough and close enough: switch to right button
      if (ms_elapsed(hold_start, now, {17'b0, hold_dur})) begin
        if (sx - half < hx && hx < sx + half && sy - half < hy && hy < sy + half) begin
          right_down = 1'b1;
          left_down  = 1'b0;
        end
      end

      // restart the hold window after twice the duration
      if (ms_elapsed(hold_start, now, {16'b0, hold_dur, 1'b0}) && !right_down) begin
        hold_start = now;
        held_x     = x;
        held_y     = y;
      end

      // forced right-button transition
      if (!was_right && right_down) begin
        clicks++;
        push_event(KIND_LEFT, '0, 1'b0);
        push_event(KIND_RIGHT, '0, 1'b0);
        push_event(KIND_SYNC, '0, 1'b0);
        push_event(KIND_LEFT, '0, 1'b0);
        push_event(KIND_RIGHT, 12'd1, 1'b0);
        push_event(KIND_SYNC, '0, 1'b0);
      end
      push_event(KIND_RIGHT, {11'b0, right_down}, 1'b0);
    end

    push_event(KIND_LEFT, {11'b0, left_down}, 1'b0);
    push_event(KIND_SYNC, '0, 1'b1);
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin : watch
    touch_event_t ev;
    logic         bad;
    if (!rst_n) begin
      rc_enable   = 1'b1;
      hold_dur    = 16'd1000;
      hold_range  = 12'd10;
      left_down   = 1'b0;
      right_down  = 1'b0;
      touch_start = '0;
      hold_start  = '0;
      held_x      = '0;
      held_y      = '0;
      queued_events.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RC_ENABLE:  rc_enable  = cfg_data[0];
          CFG_HOLD_DUR:   hold_dur   = cfg_data[DUR_W-1:0];
          CFG_HOLD_RANGE: hold_range = cfg_data[RANGE_W-1:0];
          default: ;
        endcase
      end

      // accepted sample request
      if (in_tvalid && in_tready) begin
        predict_touch_events(in_tuser, in_tdata[11:0], in_tdata[23:12], in_tdata[55:24]);
      end

      // accepted event against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (queued_events.size() == 0) begin
          fails++;
          $display("%0t: unexpected event: expected none, got kind %0d value %0d last %0b",
                   $time, out_tuser, out_tdata, out_tlast);
        end else begin
          ev  = queued_events.pop_front();
          bad = 1'b0;
          checked++;
          if (out_tuser !== ev.kind) begin
            bad = 1'b1;
            $display("%0t: event kind mismatch: expected %0d, got %0d",
                     $time, ev.kind, out_tuser);
          end
          if (out_tdata !== {4'b0, ev.value}) begin
            bad = 1'b1;
            $display("%0t: event value mismatch: expected %0d, got %0d",
                     $time, ev.value, out_tdata);
          end
          if (out_tlast !== ev.last) begin
            bad = 1'b1;
            $display("%0t: last flag mismatch: expected %0b, got %0b",
                     $time, ev.last, out_tlast);
          end
          if (bad) fails++;
        end
      end
    end
    fail_count     <= fails;
    pending_events <= queued_events.size();
    checked_events <= checked;
    right_clicks   <= clicks;
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import thrce_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD_CYCLES = 400;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [55:0]          in_tdata  = '0;
  logic                 in_tuser  = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;
  logic [KIND_W-1:0]    out_tuser;
  logic                 out_tlast;

  int fail_count;
  int pending_events;
  int checked_events;
  int right_clicks;

  // stimulus controls
  bit tx_idle   = 1'b1;
  bit rx_idle   = 1'b1;
  int long_hold_req  = 0;
  int long_hold_seen = 0;
  int samples_sent  = 0;
  int settings_used = 1;
  int cur_dur   = 1000;
  int cur_range = 10;
  logic [TIME_W-1:0] clock_ms = '0;

  touch_hold_right_click_emulator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  thrce_event_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending_events (pending_events),
    .checked_events (checked_events),
    .right_clicks   (right_clicks)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout: %0d events still outstanding", pending_events);
    $display("*** FAILED ***");
    $finish;
  end

  // event receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (long_hold_req != long_hold_seen) begin
        long_hold_seen = long_hold_req;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // one sample request, returns at the edge where it was taken
  task automatic send_sample(input logic press, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [TIME_W-1:0] t);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= press;
    in_tdata  <= {t, y, x};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drain the block, then program a new setting
  task automatic set_phase(input bit en, input int dur, input int rng, input bit poke_spare);
    logic [CFG_DAT_W-1:0] word;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    // unused upper bits carry noise
    word    = CFG_DAT_W'($urandom);
    word[0] = en;
    write_reg(CFG_RC_ENABLE, word);
    write_reg(CFG_HOLD_DUR, 16'(dur));
    word       = CFG_DAT_W'($urandom);
    word[11:0] = 12'(rng);
    write_reg(CFG_HOLD_RANGE, word);
    if (poke_spare) write_reg(CFG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    cur_dur   = dur;
    cur_range = rng;
    settings_used++;
  endtask

  // coordinate with extra weight on the edges
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // coordinate jittered around a center, kept on the panel
  function automatic logic [COORD_W-1:0] near(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return COORD_W'(v);
  endfunction

  // time to the next sample: inside no-drag, past a hold restart, or ordinary
  function automatic int next_step(input int step_max);
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, 150);
      1:       return 2 * cur_dur + $urandom_range(0, 50);
      default: return $urandom_range(1, step_max);
    endcase
  endfunction

  // touch, a few hold samples near the start point, release
  task automatic gesture();
    int cx;
    int cy;
    int spread;
    int step_max;
    int holds;
    cx       = int'(pick_coord());
    cy       = int'(pick_coord());
    spread   = cur_range / 2;
    step_max = (cur_dur / 3 > 60) ? cur_dur / 3 : 60;
    holds    = $urandom_range(1, 7);
    clock_ms = clock_ms + TIME_W'($urandom_range(1, 5000));
    send_sample(1'b1, COORD_W'(cx), COORD_W'(cy), clock_ms);
    repeat (holds) begin
      clock_ms = clock_ms + TIME_W'(next_step(step_max));
      if ($urandom_range(0, 5) == 0) send_sample(1'b1, pick_coord(), pick_coord(), clock_ms);
      else send_sample(1'b1, near(cx, spread), near(cy, spread), clock_ms);
    end
    clock_ms = clock_ms + TIME_W'(next_step(step_max));
    if ($urandom_range(0, 3) == 0) send_sample(1'b0, pick_coord(), pick_coord(), clock_ms);
    else send_sample(1'b0, near(cx, spread), near(cy, spread), clock_ms);
  endtask

  // unstructured sample, sometimes with a jump anywhere in time
  task automatic noise_sample();
    if ($urandom_range(0, 1) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + TIME_W'($urandom_range(0, 300));
    send_sample(1'($urandom_range(0, 1)), COORD_W'($urandom), COORD_W'($urandom), clock_ms);
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = samples_sent + count;
    while (samples_sent < goal) begin
      if ($urandom_range(0, 4) == 0) noise_sample();
      else gesture();
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: enable on, 1000 ms hold, range 10
    send_sample(1'b0, 12'd4095, 12'd4095, 32'd5);      // release with nothing down
    send_sample(1'b1, 12'd100, 12'd200, 32'd1000);     // first touch
    send_sample(1'b1, 12'd102, 12'd198, 32'd1100);     // inside no-drag, touch while left down
    send_sample(1'b1, 12'd101, 12'd199, 32'd1150);
    send_sample(1'b1, 12'd103, 12'd201, 32'd2050);     // hold fires right click
    send_sample(1'b1, 12'd103, 12'd201, 32'd2100);     // touch while right down
    send_sample(1'b0, 12'd0, 12'd0, 32'd2200);
    send_sample(1'b1, 12'd500, 12'd500, 32'd3000);
    send_sample(1'b1, 12'd500, 12'd500, 32'd3050);
    send_sample(1'b0, 12'd500, 12'd500, 32'd4200);     // release fires right click
    send_sample(1'b1, 12'd800, 12'd800, 32'd5000);
    send_sample(1'b1, 12'd800, 12'd800, 32'd5050);
    send_sample(1'b1, 12'd2000, 12'd2000, 32'd7500);   // moved away, hold restarts
    send_sample(1'b1, 12'd2001, 12'd2001, 32'd8600);   // fires on the restarted hold
    send_sample(1'b0, 12'd2001, 12'd2001, 32'd8700);
    send_sample(1'b1, 12'd4095, 12'd0, 32'hFFFF_FF00); // touch just before the wrap
    send_sample(1'b1, 12'd4094, 12'd1, 32'h0000_0010); // after the wrap
    send_sample(1'b0, 12'd4095, 12'd0, 32'h0000_0400);
    send_sample(1'b1, 12'd0, 12'd4095, 32'hFFFF_FFFF);
    send_sample(1'b0, 12'd0, 12'd4095, 32'h0000_0000);
    clock_ms = 32'h100;

    // zero hold time, widest range, ignored spare index
    set_phase(1'b1, 0, 4095, 1'b1);
    run_random(40);

    // right click off; receiver holds off while samples keep coming
    set_phase(1'b0, 300, 40, 1'b0);
    long_hold_req++;
    tx_idle   = 1'b0;
    run_random(14);
    tx_idle = 1'b1;
    run_random(26);

    // longest hold, zero range
    set_phase(1'b1, 65535, 0, 1'b0);
    run_random(30);

    set_phase(1'b1, 150, 20, 1'b0);
    run_random(60);

    set_phase(1'b1, 1, 1, 1'b1);
    run_random(30);

    repeat (2) begin
      set_phase($urandom_range(0, 3) != 0, $urandom_range(0, 2000), $urandom_range(0, 200), 1'b0);
      run_random(50);
    end

    // closing stretch at full rate on both sides
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_phase(1'b1, 400, 60, 1'b0);
    run_random(50);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d touch samples under %0d register settings",
             samples_sent, settings_used);
    $display("%0d events compared, %0d right clicks fired, %0d mismatching",
             checked_events, right_clicks, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
design/thrce_pkg.sv
design/thrce_front.sv
design/thrce_queue.sv
design/thrce_back.sv
design/touch_hold_right_click_emulator.sv
sim/thrce_event_checker.sv
sim/tb_top.sv
